FILE: rtl/core/fram_pkg.sv
// shared constants, types and handshake structs for the four register alu machine
`timescale 1ns / 1ps

package fram_pkg;

    // datapath sizing
    localparam int DATA_WIDTH = 64;
    localparam int NUM_REGS   = 4;
    localparam int REG_ADDR_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    // stream field widths
    localparam int OP_W      = 3;
    localparam int IDX_W     = 2;
    localparam int IMM_W     = 64;
    localparam int VALUE_W   = 64;
    localparam int IN_DATA_W = 2 * IDX_W + IMM_W;
    localparam int S_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VALUE_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    // tdata bit positions on the input side
    localparam int DST_LSB = 0;
    localparam int SRC_LSB = DST_LSB + IDX_W;
    localparam int IMM_LSB = SRC_LSB + IDX_W;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 3'd0,
        OP_MOV  = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_MUL  = 3'd4,
        OP_DIV  = 3'd5,
        OP_OUT  = 3'd6
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture a new instruction word
        logic start;    // launch the multiply/divide unit
        logic commit;   // write back and load the result register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_iter;  // operation needs the multiply/divide unit
        logic unit_done;  // multiply/divide unit finished
    } dp_status_t;

endpackage

FILE: rtl/core/fram_ram.sv
// generic register file ram, one write port and two registered read ports
`timescale 1ns / 1ps

module fram_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                         rdata_a,
    output logic [WIDTH-1:0]                         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // write port and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: rtl/core/fram_muldiv.sv
// iterative unit: shift-add multiply and restoring signed divide, one bit per cycle
`timescale 1ns / 1ps

module fram_muldiv
    import fram_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  is_div,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  div_mode_reg, div_mode_next;
    logic                  neg_reg, neg_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [DATA_WIDTH-1:0] x_reg, x_next;
    logic [DATA_WIDTH-1:0] y_reg, y_next;

    logic [DATA_WIDTH-1:0] a_mag;
    logic [DATA_WIDTH-1:0] b_mag;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH:0]   diff;
    logic [DATA_WIDTH-1:0] add_term;

    // operand magnitudes for the divide
    assign a_mag = a[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - a) : a;
    assign b_mag = b[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - b) : b;

    // one step of either algorithm
    assign rem_sh   = {acc_reg, x_reg[DATA_WIDTH-1]};
    assign diff     = rem_sh - {1'b0, y_reg};
    assign add_term = x_reg[0] ? y_reg : '0;

    // next state
    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        div_mode_next = div_mode_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        if (start)
        begin
            busy_next     = 1'b1;
            div_mode_next = is_div;
            neg_next      = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
            cnt_next      = '0;
            acc_next      = '0;
            x_next        = is_div ? a_mag : b;
            y_next        = is_div ? b_mag : a;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (div_mode_reg)
            begin
                acc_next = diff[DATA_WIDTH] ? rem_sh[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
                x_next   = {x_reg[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
            end
            else
            begin
                acc_next = acc_reg + add_term;
                x_next   = x_reg >> 1;
                y_next   = y_reg << 1;
            end
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            div_mode_reg <= 1'b0;
            neg_reg      <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            done_reg     <= done_next;
            div_mode_reg <= div_mode_next;
            neg_reg      <= neg_next;
            cnt_reg      <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    // quotient sign fix-up
    assign result = div_mode_reg ? (neg_reg ? (DATA_WIDTH'(0) - x_reg) : x_reg) : acc_reg;
    assign done   = done_reg;

endmodule

FILE: rtl/core/fram_dp.sv
// datapath: instruction word, register file, alu, multiply/divide unit, result register
`timescale 1ns / 1ps

module fram_dp
    import fram_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    input  logic [OP_W-1:0]  op,
    input  logic [IDX_W-1:0] dst_reg,
    input  logic [IDX_W-1:0] src_reg,
    input  logic [IMM_W-1:0] immediate,
    output logic [VALUE_W-1:0] value,
    output logic             is_output,
    output logic             div_fault
);

    localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    op_t                   op_reg;
    logic [IDX_W-1:0]      dst_idx_reg;
    logic [IDX_W-1:0]      src_idx_reg;
    logic [DATA_WIDTH-1:0] imm_reg;
    logic [NUM_REGS-1:0]   rf_valid_reg;
    logic                  dv_ok_reg;
    logic                  sv_ok_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic                  is_output_reg;
    logic                  div_fault_reg;

    logic [REG_ADDR_W-1:0] dst_addr;
    logic [REG_ADDR_W-1:0] src_addr;
    logic                  dst_in;
    logic                  src_in;
    logic [DATA_WIDTH-1:0] rd_dst;
    logic [DATA_WIDTH-1:0] rd_src;
    logic [DATA_WIDTH-1:0] dv;
    logic [DATA_WIDTH-1:0] sv;
    logic                  fault;
    logic                  wr_en;
    logic [DATA_WIDTH-1:0] res;
    logic [DATA_WIDTH-1:0] unit_result;
    logic                  unit_done;

    // register indexes and their range check
    assign dst_addr = REG_ADDR_W'(dst_idx_reg);
    assign src_addr = REG_ADDR_W'(src_idx_reg);
    assign dst_in   = (32'(dst_idx_reg) < NUM_REGS);
    assign src_in   = (32'(src_idx_reg) < NUM_REGS);

    // instruction word capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op_t'(op);
            dst_idx_reg <= dst_reg;
            src_idx_reg <= src_reg;
            imm_reg     <= immediate[DATA_WIDTH-1:0];
        end
    end

    // register file storage
    fram_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (NUM_REGS)
    ) u_rf (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (dst_addr),
        .wdata   (res),
        .raddr_a (dst_addr),
        .raddr_b (src_addr),
        .rdata_a (rd_dst),
        .rdata_b (rd_src)
    );

    // written flags, an unwritten or missing register reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
            dv_ok_reg    <= 1'b0;
            sv_ok_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                rf_valid_reg[dst_addr] <= 1'b1;
            end
            dv_ok_reg <= dst_in && rf_valid_reg[dst_addr];
            sv_ok_reg <= src_in && rf_valid_reg[src_addr];
        end
    end

    assign dv = dv_ok_reg ? rd_dst : '0;
    assign sv = sv_ok_reg ? rd_src : '0;

    // divide by zero or overflow
    assign fault = (op_reg == OP_DIV) && ((sv == '0) || ((dv == MOST_NEG) && (sv == '1)));

    // multiply/divide unit
    fram_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start),
        .is_div (op_reg == OP_DIV),
        .a      (dv),
        .b      (sv),
        .done   (unit_done),
        .result (unit_result)
    );

    // result select and write enable
    always_comb
    begin
        res   = dv;
        wr_en = 1'b0;
        case (op_reg)
            OP_LOAD:
            begin
                res   = imm_reg;
                wr_en = cmd.commit && dst_in;
            end
            OP_MOV:
            begin
                res   = sv;
                wr_en = cmd.commit && dst_in;
            end
            OP_ADD:
            begin
                res   = dv + sv;
                wr_en = cmd.commit && dst_in;
            end
            OP_SUB:
            begin
                res   = dv - sv;
                wr_en = cmd.commit && dst_in;
            end
            OP_MUL:
            begin
                res   = unit_result;
                wr_en = cmd.commit && dst_in;
            end
            OP_DIV:
            begin
                res   = fault ? dv : unit_result;
                wr_en = cmd.commit && dst_in && !fault;
            end
            default:
            begin
                res   = dv;
                wr_en = 1'b0;
            end
        endcase
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            value_reg     <= VALUE_W'($signed(res));
            is_output_reg <= (op_reg == OP_OUT);
            div_fault_reg <= fault;
        end
    end

    assign value     = value_reg;
    assign is_output = is_output_reg;
    assign div_fault = div_fault_reg;

    assign status.need_iter = (op_reg == OP_MUL) || ((op_reg == OP_DIV) && !fault);
    assign status.unit_done = unit_done;

endmodule

FILE: rtl/core/fram_ctrl.sv
// controller: sequences one instruction at a time and owns the output handshake
`timescale 1ns / 1ps

module fram_ctrl
    import fram_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_ITER,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // commands
    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.load   = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.start  = (state_reg == S_EXEC) && status.need_iter;
    assign cmd.commit = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = status.need_iter ? S_ITER : S_DONE;
            end
            S_ITER:
            begin
                if (status.unit_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output word valid
    assign out_valid_next = cmd.commit || (out_valid_reg && !m_tready);

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    // a result is never written over one that is still waiting
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || m_tready))
        else $error("result committed over a waiting word");

    // one instruction at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while busy");

    // the unit only finishes while the controller waits for it
    a_done_in_iter: assert property (@(posedge clk) disable iff (!rst_n)
        status.unit_done |-> (state_reg == S_ITER))
        else $error("unit done outside the wait state");

    // output valid only rises after a commit
    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("output valid without a commit");

endmodule

FILE: rtl/core/four_register_alu_machine.sv
// Four register alu machine: executes decoded instructions on a small signed register file.
// Input stream (s_axis): one instruction per word; tuser carries the operation code,
// tdata the destination index, source index and signed immediate.
// Output stream (m_axis): exactly one result word per instruction; tdata carries the
// destination value after the operation (or the reported register), tuser the flags.
// Load, move, add, subtract, output and faulted divides pass from accept through the
// read, execute and done states to the result register; multiply and divide also run
// DATA_WIDTH steps of one shared shift-add / restoring unit in the iterate state.
// One instruction is in flight at a time, so a new word is accepted only once the
// last result has gone to the result register.
// Reset clears all registers to zero and empties the result register.
// The result register parts the two sides: a new instruction is accepted while the
// last result waits; if the receiver still stalls when the next result is ready,
// the block holds that result internally and takes no further words.
`timescale 1ns / 1ps

module four_register_alu_machine
    import fram_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // dst_reg, src_reg, immediate, zero pad
    input  logic [OP_W-1:0]      s_axis_tuser,   // op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // value
    output logic [M_TUSER_W-1:0] m_axis_tuser    // is_output, div_fault
);

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [VALUE_W-1:0] value;
    logic               is_output;
    logic               div_fault;

    // sequencing
    fram_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // execution
    fram_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .op        (s_axis_tuser),
        .dst_reg   (s_axis_tdata[DST_LSB +: IDX_W]),
        .src_reg   (s_axis_tdata[SRC_LSB +: IDX_W]),
        .immediate (s_axis_tdata[IMM_LSB +: IMM_W]),
        .value     (value),
        .is_output (is_output),
        .div_fault (div_fault)
    );

    // output packing
    assign m_axis_tdata = M_TDATA_W'(value);
    assign m_axis_tuser = {div_fault, is_output};

endmodule
